/* rtl/i2c_master_bit_engine_defines.svh */
// Assertion macros used by the checker file
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

    // Default widths and depths
    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Field widths
    localparam int TPU_W      = 16;
    localparam int ACK_LIM_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 16;
    localparam int S_USER_W   = 4;
    localparam int M_DATA_W   = 16;

    // Reset values of the configuration registers
    localparam logic [TPU_W-1:0]     TPU_RST     = 16'd100;
    localparam logic [ACK_LIM_W-1:0] ACK_LIM_RST = 16'd250;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TICKS_PER_UNIT = 1'b0,
        CFG_ACK_WAIT_LIMIT = 1'b1
    } t_cfg_idx;

    // Command codes
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_ACK      = 3'd4,
        OP_NACK     = 3'd5,
        OP_WAIT_ACK = 3'd6
    } t_op;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic       go;    // a command is to be started if the sequencer is idle
        t_op        op;
        logic [7:0] data;
        logic       sda;
    } t_item;

    // Queue to sequencer handshake
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

/* rtl/i2cm_front.sv */
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic [S_USER_W-1:0] i_s_tuser,  // cmd_valid[0], opcode[3:1]
    input  logic [S_DATA_W-1:0] i_s_tdata,  // write_data[7:0], sda_in[8]
    output t_item               o_item
);

    logic       cmd_valid;
    logic [2:0] opcode;

    assign cmd_valid = i_s_tuser[0];
    assign opcode    = i_s_tuser[3:1];

    // Classify: the unused opcode never starts a command
    always_comb begin
        o_item.go   = 1'b0;
        o_item.op   = OP_START;
        o_item.data = i_s_tdata[7:0];
        o_item.sda  = i_s_tdata[8];
        unique case (opcode)
            OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK, OP_NACK, OP_WAIT_ACK: begin
                o_item.go = cmd_valid;
                o_item.op = t_op'(opcode);
            end
            default: begin
                o_item.go = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/i2cm_queue.sv */
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_item     o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == FULL);
    assign o_item         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Item storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/i2cm_back.sv */
module i2cm_back
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_q_status             i_q_status,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // read_data[12:5], no_ack[13], zero fill[15:14]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    // Sequencer phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE   = 15'b000000000000001,
        PH_START1 = 15'b000000000000010,
        PH_START2 = 15'b000000000000100,
        PH_STOP1  = 15'b000000000001000,
        PH_STOP2  = 15'b000000000010000,
        PH_ACK1   = 15'b000000000100000,
        PH_ACK2   = 15'b000000001000000,
        PH_WA1    = 15'b000000010000000,
        PH_WA2    = 15'b000000100000000,
        PH_POLL   = 15'b000001000000000,
        PH_WR1    = 15'b000010000000000,
        PH_WR2    = 15'b000100000000000,
        PH_WR3    = 15'b001000000000000,
        PH_RD1    = 15'b010000000000000,
        PH_RD2    = 15'b100000000000000
    } t_phase;

    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNTER_WIDTH) - 33'd1;
    localparam logic [31:0] CNT_MAX   = CNT_MAX_W[31:0];

    // Configuration
    logic [TPU_W-1:0]     r_tpu;
    logic [ACK_LIM_W-1:0] r_ack_lim;

    // Sequencer state
    t_phase                   r_phase,   n_phase;
    logic                     r_is_wait, n_is_wait;
    logic [COUNTER_WIDTH-1:0] r_delay,   n_delay;
    logic [1:0]               r_units,   n_units;
    logic [3:0]               r_bit,     n_bit;
    logic [7:0]               r_shift,   n_shift;
    logic [COUNTER_WIDTH-1:0] r_ack_cnt, n_ack_cnt;
    logic                     r_scl,     n_scl;
    logic                     r_sda,     n_sda;
    logic                     r_drv,     n_drv;
    logic                     r_no_ack,  n_no_ack;
    logic                     n_done;
    logic [7:0]               r_rd_byte, n_rd_byte;

    // Output register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic                     step;
    logic [COUNTER_WIDTH-1:0] tload;
    logic [31:0]              lim_ext;

    assign step       = i_q_status.valid && (!r_out_valid || i_m_tready);
    assign o_pop      = step;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Delay reload and ack limit, saturated to the counter range
    always_comb begin
        logic [31:0] t_ext;
        t_ext = 32'(r_tpu);
        if (t_ext == 32'd0) begin
            t_ext = 32'd1;
        end
        if (t_ext > CNT_MAX) begin
            t_ext = CNT_MAX;
        end
        tload   = t_ext[COUNTER_WIDTH-1:0];
        lim_ext = (32'(r_ack_lim) > CNT_MAX) ? CNT_MAX : 32'(r_ack_lim);
    end

    // One sequencer tick
    always_comb begin
        logic [COUNTER_WIDTH-1:0] poll_cnt;
        logic                     do_poll;
        logic                     do_stop;
        logic                     do_wbit;
        logic                     do_rbit;

        n_phase   = r_phase;
        n_is_wait = r_is_wait;
        n_delay   = r_delay;
        n_units   = r_units;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_ack_cnt = r_ack_cnt;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        n_no_ack  = r_no_ack;
        n_done    = 1'b0;
        n_rd_byte = r_rd_byte;
        poll_cnt  = r_ack_cnt;
        do_poll   = 1'b0;
        do_stop   = 1'b0;
        do_wbit   = 1'b0;
        do_rbit   = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.go) begin
                    n_is_wait = (i_item.op == OP_WAIT_ACK);
                    n_bit     = 4'd0;
                    unique case (i_item.op)
                        OP_START: begin
                            n_drv   = 1'b1;
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_START1;
                        end
                        OP_STOP: begin
                            do_stop = 1'b1;
                        end
                        OP_WRITE: begin
                            n_drv   = 1'b1;
                            n_shift = i_item.data;
                            do_wbit = 1'b1;
                        end
                        OP_READ: begin
                            n_sda   = 1'b1;
                            n_drv   = 1'b0;
                            n_shift = 8'd0;
                            do_rbit = 1'b1;
                        end
                        OP_ACK, OP_NACK: begin
                            n_scl   = 1'b0;
                            n_drv   = 1'b1;
                            n_sda   = (i_item.op == OP_NACK);
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_ACK1;
                        end
                        OP_WAIT_ACK: begin
                            n_no_ack = 1'b0;
                            n_sda    = 1'b1;
                            n_units  = 2'd2;
                            n_delay  = tload;
                            n_phase  = PH_WA1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_POLL: begin
                do_poll = 1'b1;
            end
            default: begin
                if (r_delay > COUNTER_WIDTH'(1)) begin
                    n_delay = r_delay - 1'b1;
                end else if (r_units > 2'd1) begin
                    n_units = r_units - 1'b1;
                    n_delay = tload;
                end else begin
                    // Interval over: apply the next line settings
                    unique case (r_phase)
                        PH_START1: begin
                            n_sda   = 1'b0;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_START2;
                        end
                        PH_START2: begin
                            n_scl   = 1'b0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                        PH_STOP1: begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_STOP2;
                        end
                        PH_STOP2: begin
                            if (r_is_wait) begin
                                n_no_ack = 1'b1;
                            end
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                        PH_ACK1: begin
                            n_scl   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_ACK2;
                        end
                        PH_ACK2: begin
                            n_scl   = 1'b0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                        PH_WA1: begin
                            n_drv   = 1'b0;
                            n_scl   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_WA2;
                        end
                        PH_WA2: begin
                            n_phase  = PH_POLL;
                            poll_cnt = '0;
                            do_poll  = 1'b1;
                        end
                        PH_WR1: begin
                            n_scl   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_WR2;
                        end
                        PH_WR2: begin
                            n_scl   = 1'b0;
                            n_units = 2'd1;
                            n_delay = tload;
                            n_phase = PH_WR3;
                        end
                        PH_WR3: begin
                            n_bit = r_bit + 1'b1;
                            if (n_bit < 4'd8) begin
                                do_wbit = 1'b1;
                            end else begin
                                n_sda   = 1'b1;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                        end
                        PH_RD1: begin
                            n_scl   = 1'b1;
                            n_units = 2'd2;
                            n_delay = tload;
                            n_phase = PH_RD2;
                        end
                        PH_RD2: begin
                            n_shift = {r_shift[7:1], r_shift[0] | i_item.sda};
                            n_bit   = r_bit + 1'b1;
                            if (n_bit < 4'd8) begin
                                do_rbit = 1'b1;
                            end else begin
                                n_scl     = 1'b0;
                                n_rd_byte = n_shift;
                                n_phase   = PH_IDLE;
                                n_done    = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // Ack polling: low SDA ends, too many high samples send a stop
        if (do_poll) begin
            n_ack_cnt = poll_cnt;
            if (!i_item.sda) begin
                n_scl    = 1'b0;
                n_no_ack = 1'b0;
                n_phase  = PH_IDLE;
                n_done   = 1'b1;
            end else if (32'(poll_cnt) >= lim_ext) begin
                do_stop = 1'b1;
            end else begin
                n_ack_cnt = poll_cnt + 1'b1;
            end
        end

        // Stop sequence start
        if (do_stop) begin
            n_drv   = 1'b1;
            n_scl   = 1'b0;
            n_sda   = 1'b0;
            n_units = 2'd2;
            n_delay = tload;
            n_phase = PH_STOP1;
        end

        // Next write bit, MSB first
        if (do_wbit) begin
            n_sda   = n_shift[7];
            n_shift = {n_shift[6:0], 1'b0};
            n_units = 2'd1;
            n_delay = tload;
            n_phase = PH_WR1;
        end

        // Next read bit
        if (do_rbit) begin
            n_shift = {n_shift[6:0], 1'b0};
            n_scl   = 1'b0;
            n_units = 2'd2;
            n_delay = tload;
            n_phase = PH_RD1;
        end
    end

    // Configuration and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu       <= TPU_RST;
            r_ack_lim   <= ACK_LIM_RST;
            r_phase     <= PH_IDLE;
            r_is_wait   <= 1'b0;
            r_delay     <= '0;
            r_units     <= 2'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_ack_cnt   <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drv       <= 1'b1;
            r_no_ack    <= 1'b0;
            r_rd_byte   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TICKS_PER_UNIT: r_tpu     <= i_cfg_wdata[TPU_W-1:0];
                    CFG_ACK_WAIT_LIMIT: r_ack_lim <= i_cfg_wdata[ACK_LIM_W-1:0];
                    default: ;
                endcase
            end
            if (step) begin
                r_phase   <= n_phase;
                r_is_wait <= n_is_wait;
                r_delay   <= n_delay;
                r_units   <= n_units;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_ack_cnt <= n_ack_cnt;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_drv     <= n_drv;
                r_no_ack  <= n_no_ack;
                r_rd_byte <= n_rd_byte;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {2'b00, n_no_ack, n_rd_byte, n_done,
                           (n_phase != PH_IDLE), n_drv, n_sda, n_scl};
        end
    end

endmodule

/* rtl/i2c_master_bit_engine.sv */
// I2C master bit engine. Each input item is one tick of the line sequencer and
// yields exactly one result item giving SCL, SDA, drive enable, busy, done,
// the last read byte and the no-ack flag after that tick. A new item is taken
// every cycle: the front classifies it, a two-item queue decouples it from the
// sequencer, and the sequencer advances one tick per cycle into an output
// register, so results come out at one per cycle, each presented after its
// item has passed the queue. The single-tick sequencer step sets the rate.
// A stalled result holds the sequencer, and the input stalls once the queue
// is full. Commands offered while busy are ignored; timed intervals are
// multiples of ticks_per_delay_unit. There is no clock stretching and no
// arbitration.
module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // write_data[7:0], sda_in[8]
    input  logic [S_USER_W-1:0]   i_s_tuser,   // cmd_valid[0], opcode[3:1]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // read_data[12:5], no_ack[13]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    t_item     front_item;
    t_item     q_item;
    t_q_status q_status;
    logic      q_pop;

    assign o_s_tready = !q_status.full;

    i2cm_front u_front (
        .i_s_tuser (i_s_tuser),
        .i_s_tdata (i_s_tdata),
        .o_item    (front_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_s_tvalid),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_item   (q_item)
    );

    i2cm_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_status  (q_status),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

/* rtl/i2cm_checker.sv */
`include "i2c_master_bit_engine_defines.svh"

module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_DATA_W-1:0]   o_m_tdata
);

    // A stalled result holds
    `I2CM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // The queue only fills up when a result is waiting downstream
    `I2CM_ASSERT_IMP(a_full_out, i_clk, i_rst_n, !o_s_tready, o_m_tvalid, "queue full while output register empty")

    // A finishing tick leaves the sequencer idle
    `I2CM_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[4], !o_m_tdata[3], "done while still busy")

    // SDA is released only with its level set high
    `I2CM_ASSERT_IMP(a_rel_high, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[2], o_m_tdata[1], "SDA released with low level")

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (.*);

/* test/tb_i2c_master_bit_engine.sv */
module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    // Opcode that the engine must ignore
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // SDA policy for the ticks of a command that are not ack polls
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    // Quiet cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 8;
    // Command ticks per random traffic phase
    localparam int RAND_TICKS    = 60;

    // Line sequencer phases of the predictor
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START_A, SQ_START_B, SQ_STOP_A, SQ_STOP_B, SQ_ACK_A, SQ_ACK_B,
        SQ_WA_A, SQ_WA_B, SQ_POLL, SQ_WR_A, SQ_WR_B, SQ_WR_C, SQ_RD_A, SQ_RD_B
    } t_seq;

    // Line levels and status after one tick, laid out as in o_m_tdata
    typedef struct packed {
        logic       noack;
        logic [7:0] rdata;
        logic       done;
        logic       busy;
        logic       drv;
        logic       sda;
        logic       scl;
    } t_lines;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [0:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;   // write_data[7:0], sda_in[8]
    logic [S_USER_W-1:0]   i_s_tuser   = '0;   // cmd_valid[0], opcode[3:1]
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // read_data[12:5], no_ack[13]
    logic [M_DATA_W-1:0]   o_m_tdata;

    i2c_master_bit_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Predicted engine state, starting at its reset values
    logic [15:0] tpu_reg     = TPU_RST;
    logic [15:0] ack_lim_reg = ACK_LIM_RST;
    t_seq        seq_ph      = SQ_IDLE;
    logic [2:0]  cur_op      = '0;
    logic [15:0] dly_cnt     = '0;
    logic [1:0]  units_left  = '0;
    logic [3:0]  bit_cnt     = '0;
    logic [7:0]  shift_reg   = '0;
    logic [15:0] poll_cnt    = '0;
    logic        scl_l       = 1'b1;
    logic        sda_l       = 1'b1;
    logic        drv_l       = 1'b1;
    logic        done_f      = 1'b0;
    logic        noack_f     = 1'b0;
    logic [7:0]  rd_byte     = '0;

    t_lines line_q[$];     // predicted line states not yet seen on the output
    int     err_cnt      = 0;
    int     cmd_ticks    = 0;
    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;

    // ---------------------------------------------------------------
    // Line sequencer predictor
    // ---------------------------------------------------------------

    // Enter phase nxt and hold the lines there for n delay units
    function automatic void hold_units(logic [1:0] n, t_seq nxt);
        units_left = n;
        dly_cnt    = (tpu_reg == '0) ? 16'd1 : tpu_reg;
        seq_ph     = nxt;
    endfunction

    function automatic void end_cmd();
        seq_ph = SQ_IDLE;
        done_f = 1'b1;
    endfunction

    function automatic void stop_seq();
        drv_l = 1'b1;
        scl_l = 1'b0;
        sda_l = 1'b0;
        hold_units(2'd2, SQ_STOP_A);
    endfunction

    function automatic void wr_bit();
        sda_l     = shift_reg[7];
        shift_reg = shift_reg << 1;
        hold_units(2'd1, SQ_WR_A);
    endfunction

    function automatic void rd_bit();
        shift_reg = shift_reg << 1;
        scl_l     = 1'b0;
        hold_units(2'd2, SQ_RD_A);
    endfunction

    // One ack poll: low ends the command, too many highs turn into a stop
    function automatic void poll_sda(logic sda);
        if (!sda) begin
            scl_l   = 1'b0;
            noack_f = 1'b0;
            end_cmd();
        end else if (poll_cnt >= ack_lim_reg) begin
            stop_seq();
        end else begin
            poll_cnt = poll_cnt + 1'b1;
        end
    endfunction

    // Step taken when the current hold has run out
    function automatic void advance_seq(logic sda);
        case (seq_ph)
            SQ_START_A: begin
                sda_l = 1'b0;
                hold_units(2'd2, SQ_START_B);
            end
            SQ_START_B: begin
                scl_l = 1'b0;
                end_cmd();
            end
            SQ_STOP_A: begin
                scl_l = 1'b1;
                sda_l = 1'b1;
                hold_units(2'd2, SQ_STOP_B);
            end
            SQ_STOP_B: begin
                if (cur_op == OP_WAIT_ACK) noack_f = 1'b1;
                end_cmd();
            end
            SQ_ACK_A: begin
                scl_l = 1'b1;
                hold_units(2'd2, SQ_ACK_B);
            end
            SQ_ACK_B: begin
                scl_l = 1'b0;
                end_cmd();
            end
            SQ_WA_A: begin
                drv_l = 1'b0;
                scl_l = 1'b1;
                hold_units(2'd2, SQ_WA_B);
            end
            SQ_WA_B: begin
                seq_ph   = SQ_POLL;
                poll_cnt = '0;
                poll_sda(sda);
            end
            SQ_WR_A: begin
                scl_l = 1'b1;
                hold_units(2'd2, SQ_WR_B);
            end
            SQ_WR_B: begin
                scl_l = 1'b0;
                hold_units(2'd1, SQ_WR_C);
            end
            SQ_WR_C: begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < 4'd8) begin
                    wr_bit();
                end else begin
                    sda_l = 1'b1;
                    end_cmd();
                end
            end
            SQ_RD_A: begin
                scl_l = 1'b1;
                hold_units(2'd2, SQ_RD_B);
            end
            SQ_RD_B: begin
                if (sda) shift_reg[0] = 1'b1;
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < 4'd8) begin
                    rd_bit();
                end else begin
                    scl_l   = 1'b0;
                    rd_byte = shift_reg;
                    end_cmd();
                end
            end
            default: seq_ph = SQ_IDLE;
        endcase
    endfunction

    // First line settings of a newly taken command
    function automatic void start_cmd(logic [2:0] op, logic [7:0] d);
        cur_op  = op;
        bit_cnt = '0;
        case (op)
            OP_START: begin
                drv_l = 1'b1;
                sda_l = 1'b1;
                scl_l = 1'b1;
                hold_units(2'd2, SQ_START_A);
            end
            OP_STOP: stop_seq();
            OP_WRITE: begin
                drv_l     = 1'b1;
                shift_reg = d;
                wr_bit();
            end
            OP_READ: begin
                sda_l     = 1'b1;
                drv_l     = 1'b0;
                shift_reg = '0;
                rd_bit();
            end
            OP_ACK, OP_NACK: begin
                scl_l = 1'b0;
                drv_l = 1'b1;
                sda_l = (op == OP_NACK);
                hold_units(2'd2, SQ_ACK_A);
            end
            default: begin
                noack_f = 1'b0;
                sda_l   = 1'b1;
                hold_units(2'd2, SQ_WA_A);
            end
        endcase
    endfunction

    // One tick of the engine; gives the line state after it
    function automatic t_lines step_line(logic cv, logic [2:0] op, logic [7:0] d,
                                         logic sda);
        t_lines r;
        done_f = 1'b0;
        if (seq_ph == SQ_IDLE) begin
            if (cv && op != OP_UNUSED) start_cmd(op, d);
        end else if (seq_ph == SQ_POLL) begin
            poll_sda(sda);
        end else if (dly_cnt > 16'd1) begin
            dly_cnt = dly_cnt - 1'b1;
        end else if (units_left > 2'd1) begin
            hold_units(units_left - 1'b1, seq_ph);
        end else begin
            advance_seq(sda);
        end
        r.scl   = scl_l;
        r.sda   = sda_l;
        r.drv   = drv_l;
        r.busy  = (seq_ph != SQ_IDLE);
        r.done  = done_f;
        r.rdata = rd_byte;
        r.noack = noack_f;
        return r;
    endfunction

    // Next tick samples SDA for the ack
    function automatic logic polls_now();
        return seq_ph == SQ_POLL ||
               (seq_ph == SQ_WA_B && dly_cnt <= 16'd1 && units_left <= 2'd1);
    endfunction

    // High ack samples for a random wait-ack; -1 keeps SDA high for a timeout
    function automatic int pick_highs();
        if ($urandom_range(0, 3) == 0) return -1;
        return int'($urandom_range(0, ack_lim_reg + 1));
    endfunction

    // ---------------------------------------------------------------
    // Clock, time limit
    // ---------------------------------------------------------------

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("tb_i2c_master_bit_engine failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one tick item, wait for it to be taken, then predict it
    task automatic send_tick(logic cv, logic [2:0] op, logic [7:0] d, logic sda);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-9){1'b0}}, sda, d};
        i_s_tuser  <= {op, cv};
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        line_q.push_back(step_line(cv, op, d, sda));
    endtask

    // Idle tick: no command, or the unused opcode
    task automatic idle_tick();
        if ($urandom_range(0, 1))
            send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        else
            send_tick(1'b1, OP_UNUSED, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Issue one command and tick it through to completion; the ticks while
    // busy carry random commands that must be ignored
    task automatic run_cmd(logic [2:0] op, logic [7:0] d, int highs, int sda_mode);
        int   n_high;
        logic s;
        n_high = 0;
        repeat ($urandom_range(0, 2)) idle_tick();
        send_tick(1'b1, op, d, 1'($urandom_range(0, 1)));
        cmd_ticks++;
        while (seq_ph != SQ_IDLE) begin
            if (polls_now()) begin
                s = (highs < 0 || n_high < highs);
                n_high++;
            end else if (sda_mode == SDA_RAND) begin
                s = 1'($urandom_range(0, 1));
            end else begin
                s = (sda_mode == SDA_HIGH);
            end
            send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), s);
            cmd_ticks++;
        end
    endtask

    // Stop offering items and wait until every predicted result is out
    task automatic wait_bus_quiet();
        i_s_tvalid <= 1'b0;
        while (line_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] v);
        wait_bus_quiet();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TICKS_PER_UNIT) tpu_reg = v;
        else ack_lim_reg = v;
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void check_bit(string name, logic want, logic got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    initial begin : result_check
        t_lines got;
        t_lines want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = t_lines'(o_m_tdata[$bits(t_lines)-1:0]);
                if (line_q.size() == 0) begin
                    $display("%0t: result expected none got %h", $time, got);
                    err_cnt++;
                end else begin
                    want = line_q.pop_front();
                    check_bit("scl_out",     want.scl,   got.scl);
                    check_bit("sda_out",     want.sda,   got.sda);
                    check_bit("sda_drive",   want.drv,   got.drv);
                    check_bit("busy",        want.busy,  got.busy);
                    check_bit("done",        want.done,  got.done);
                    check_field("read_data", want.rdata, got.rdata);
                    check_bit("no_ack",      want.noack, got.noack);
                end
            end
            @(posedge i_clk);
            i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Lines and flags straight after reset
    task automatic test_reset_state();
        repeat (8) idle_tick();
    endtask

    // Every command, byte extremes, ack at and past the poll limit
    task automatic test_commands();
        cfg_write(CFG_TICKS_PER_UNIT, 16'd1);
        cfg_write(CFG_ACK_WAIT_LIMIT, 16'd2);
        run_cmd(OP_START, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WRITE, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WRITE, 8'hFF, 0, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'h00, 1, SDA_RAND);
        run_cmd(OP_WRITE, 8'hA5, 0, SDA_RAND);
        // ack on the last poll still within the limit
        run_cmd(OP_WAIT_ACK, 8'h00, 2, SDA_RAND);
        run_cmd(OP_READ, 8'h00, 0, SDA_HIGH);
        run_cmd(OP_ACK, 8'h00, 0, SDA_RAND);
        run_cmd(OP_READ, 8'hFF, 0, SDA_LOW);
        run_cmd(OP_NACK, 8'h00, 0, SDA_RAND);
        run_cmd(OP_READ, 8'h5A, 0, SDA_RAND);
        run_cmd(OP_NACK, 8'h00, 0, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, 0, SDA_RAND);

        // one high sample too many: stop is sent and no-ack latched
        run_cmd(OP_START, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 0, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'h00, 3, SDA_RAND);
        // no-ack survives other commands until the next wait-ack
        run_cmd(OP_START, 8'h00, 0, SDA_RAND);
        run_cmd(OP_READ, 8'h00, 0, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'h00, 0, SDA_RAND);
    endtask

    // Register extremes: zero unit length, zero and full-scale poll limit
    task automatic test_register_extremes();
        cfg_write(CFG_TICKS_PER_UNIT, 16'd0);
        run_cmd(OP_START, 8'h00, 0, SDA_RAND);
        run_cmd(OP_WRITE, 8'h3C, 0, SDA_RAND);
        cfg_write(CFG_ACK_WAIT_LIMIT, 16'd0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'h00, 0, SDA_RAND);
        cfg_write(CFG_TICKS_PER_UNIT, 16'd1);
        cfg_write(CFG_ACK_WAIT_LIMIT, 16'hFFFF);
        run_cmd(OP_WAIT_ACK, 8'h00, 40, SDA_RAND);
    endtask

    // Start, address, ack, a few data bytes, stop; a timeout ends it early
    task automatic rand_transfer();
        int n_bytes;
        int i;
        n_bytes = $urandom_range(1, 3);
        i       = 0;
        run_cmd(OP_START, 8'($urandom_range(0, 255)), 0, SDA_RAND);
        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 0, SDA_RAND);
        run_cmd(OP_WAIT_ACK, 8'($urandom_range(0, 255)), pick_highs(), SDA_RAND);
        while (i < n_bytes && !noack_f) begin
            if ($urandom_range(0, 1)) begin
                run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 0, SDA_RAND);
                run_cmd(OP_WAIT_ACK, 8'($urandom_range(0, 255)), pick_highs(),
                        SDA_RAND);
            end else begin
                run_cmd(OP_READ, 8'($urandom_range(0, 255)), 0, SDA_RAND);
                run_cmd($urandom_range(0, 1) ? OP_ACK : OP_NACK,
                        8'($urandom_range(0, 255)), 0, SDA_RAND);
            end
            i++;
        end
        if (!noack_f) run_cmd(OP_STOP, 8'($urandom_range(0, 255)), 0, SDA_RAND);
    endtask

    // Mostly well-formed transfers, some lone commands in any order
    task automatic test_random_traffic();
        int tick0;
        tick0 = cmd_ticks;
        cfg_write(CFG_TICKS_PER_UNIT, 16'($urandom_range(1, 2)));
        cfg_write(CFG_ACK_WAIT_LIMIT, 16'($urandom_range(0, 6)));
        while (cmd_ticks - tick0 < RAND_TICKS) begin
            if ($urandom_range(0, 7) == 0) begin
                cfg_write(CFG_TICKS_PER_UNIT, 16'($urandom_range(1, 2)));
                cfg_write(CFG_ACK_WAIT_LIMIT, 16'($urandom_range(0, 6)));
            end
            if ($urandom_range(0, 4) != 0)
                rand_transfer();
            else
                run_cmd(3'($urandom_range(OP_START, OP_WAIT_ACK)),
                        8'($urandom_range(0, 255)), pick_highs(), SDA_RAND);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence of tests
    // ---------------------------------------------------------------

    initial begin
        src_idle_pct = 20;
        snk_idle_pct = 56;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_commands();
        test_random_traffic();

        src_idle_pct = 56;
        snk_idle_pct = 20;
        test_random_traffic();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_register_extremes();
        test_random_traffic();

        wait_bus_quiet();
        if (err_cnt == 0)
            $display("tb_i2c_master_bit_engine passed");
        else
            $display("tb_i2c_master_bit_engine failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
test/tb_i2c_master_bit_engine.sv
